/* hw/rtl/bmp_px_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package bmp_px_pkg;

  localparam logic [1:0] MODE_MASK16 = 2'd0;
  localparam logic [1:0] MODE_RGB24  = 2'd1;
  localparam logic [1:0] MODE_RGBA32 = 2'd2;

  localparam logic [2:0] REG_PIXEL_MODE = 3'd0;
  localparam logic [2:0] REG_RED_MASK   = 3'd1;
  localparam logic [2:0] REG_GREEN_MASK = 3'd2;
  localparam logic [2:0] REG_BLUE_MASK  = 3'd3;
  localparam logic [2:0] REG_ALPHA_MASK = 3'd4;

  localparam logic [31:0] LANE0_MASK = 32'h0000_00ff;
  localparam logic [31:0] LANE1_MASK = 32'h0000_ff00;
  localparam logic [31:0] LANE2_MASK = 32'h00ff_0000;
  localparam logic [31:0] LANE3_MASK = 32'hff00_0000;

  localparam logic [31:0] RST_RED_MASK   = 32'h0000_f800;
  localparam logic [31:0] RST_GREEN_MASK = 32'h0000_07e0;
  localparam logic [31:0] RST_BLUE_MASK  = 32'h0000_001f;
  localparam logic [31:0] RST_ALPHA_MASK = 32'h0000_0000;

  localparam logic [7:0] FULL_BYTE = 8'hff;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       has_alpha;
    logic       error;
  } pix_res_t;

  typedef struct packed {
    logic ok;
    logic [1:0] lane;
  } lane_sel_t;

endpackage

`default_nettype wire

/* hw/rtl/bmp_pixel_to_rgba8.sv */
`timescale 1ns / 1ps
`default_nettype none

// BMP pixel to RGBA8 converter. One pixel word enters per clock while the output is not
// stalled, and its result leaves through the three-stage pipeline (mask decode and field
// extract, field width trim, bit-replicating widen), which sets the rate of one pixel per
// clock. When a result waits on a stalled output the whole pipeline holds. Configuration
// registers are written through the cfg_ port, which is always ready, and must only change
// while no pixel is in flight.
module bmp_pixel_to_rgba8 (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_pixel_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  output logic             out_has_alpha,
  output logic             out_error
);

  function automatic logic [3:0] tz16(input logic [15:0] m);
    logic [3:0] s;
    s = 4'd0;
    for (int i = 15; i >= 0; i--) begin
      if (m[i]) s = 4'(i);
    end
    return s;
  endfunction

  function automatic logic [4:0] to16(input logic [15:0] m);
    logic [4:0] n;
    n = 5'd16;
    for (int i = 15; i >= 0; i--) begin
      if (!m[i]) n = 5'(i);
    end
    return n;
  endfunction

  function automatic logic [7:0] widen(input logic [15:0] f, input logic [4:0] wd);
    logic [7:0]  acc;
    logic [15:0] t;
    int          pos;
    acc = 8'd0;
    t   = 16'd0;
    pos = 8;
    if (wd >= 5'd8) begin
      t   = f >> (wd - 5'd8);
      acc = t[7:0];
    end else if (wd != 5'd0) begin
      for (int k = 0; k < 8; k++) begin
        if (pos > 0) begin
          pos = pos - int'(wd);
          if (pos >= 0) t = f << pos;
          else t = f >> (-pos);
          acc = acc | t[7:0];
        end
      end
    end
    return acc;
  endfunction

  function automatic bmp_px_pkg::lane_sel_t lane_of(input logic [31:0] m);
    bmp_px_pkg::lane_sel_t s;
    unique case (m)
      bmp_px_pkg::LANE0_MASK: s = '{ok: 1'b1, lane: 2'd0};
      bmp_px_pkg::LANE1_MASK: s = '{ok: 1'b1, lane: 2'd1};
      bmp_px_pkg::LANE2_MASK: s = '{ok: 1'b1, lane: 2'd2};
      bmp_px_pkg::LANE3_MASK: s = '{ok: 1'b1, lane: 2'd3};
      default:                s = '{ok: 1'b0, lane: 2'd0};
    endcase
    return s;
  endfunction

  logic [1:0]  pixel_mode_r;
  logic [31:0] red_mask_r;
  logic [31:0] green_mask_r;
  logic [31:0] blue_mask_r;
  logic [31:0] alpha_mask_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixel_mode_r <= bmp_px_pkg::MODE_MASK16;
      red_mask_r   <= bmp_px_pkg::RST_RED_MASK;
      green_mask_r <= bmp_px_pkg::RST_GREEN_MASK;
      blue_mask_r  <= bmp_px_pkg::RST_BLUE_MASK;
      alpha_mask_r <= bmp_px_pkg::RST_ALPHA_MASK;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bmp_px_pkg::REG_PIXEL_MODE: pixel_mode_r <= cfg_data[1:0];
        bmp_px_pkg::REG_RED_MASK:   red_mask_r   <= cfg_data;
        bmp_px_pkg::REG_GREEN_MASK: green_mask_r <= cfg_data;
        bmp_px_pkg::REG_BLUE_MASK:  blue_mask_r  <= cfg_data;
        bmp_px_pkg::REG_ALPHA_MASK: alpha_mask_r <= cfg_data;
        default: ;
      endcase
    end
  end

  logic advance;
  logic v1_r, v2_r, v3_r;

  assign in_stall  = v3_r && out_stall;
  assign advance   = !in_stall;
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (advance) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // stage 1: decode masks, extract fields, resolve byte modes
  logic [2:0][15:0] chan_mask;
  logic [2:0][15:0] fs_nxt;
  logic [2:0][15:0] ms_nxt;
  logic [15:0]      w16;
  logic [3:0]       sh;
  bmp_px_pkg::pix_res_t  s1_nxt;
  bmp_px_pkg::lane_sel_t lr, lg, lb, la;
  logic             direct;

  assign chan_mask[0] = red_mask_r[15:0];
  assign chan_mask[1] = green_mask_r[15:0];
  assign chan_mask[2] = blue_mask_r[15:0];
  assign w16 = in_pixel_word[15:0];

  always_comb begin
    sh = 4'd0;
    for (int c = 0; c < 3; c++) begin
      sh        = tz16(chan_mask[c]);
      fs_nxt[c] = (w16 & chan_mask[c]) >> sh;
      ms_nxt[c] = chan_mask[c] >> sh;
    end
  end

  assign lr = lane_of(red_mask_r);
  assign lg = lane_of(green_mask_r);
  assign lb = lane_of(blue_mask_r);
  assign la = lane_of(alpha_mask_r);
  assign direct = (red_mask_r == bmp_px_pkg::LANE0_MASK) &&
                  (green_mask_r == bmp_px_pkg::LANE1_MASK) &&
                  (blue_mask_r == bmp_px_pkg::LANE2_MASK);

  always_comb begin
    s1_nxt = '0;
    unique case (pixel_mode_r)
      bmp_px_pkg::MODE_MASK16: begin
        if (alpha_mask_r != 32'd0) begin
          s1_nxt.has_alpha = 1'b1;
          s1_nxt.alpha = ((w16 & alpha_mask_r[15:0]) != 16'd0) ? bmp_px_pkg::FULL_BYTE : 8'd0;
        end
      end
      bmp_px_pkg::MODE_RGB24: begin
        s1_nxt.green = in_pixel_word[15:8];
        s1_nxt.red   = direct ? in_pixel_word[7:0] : in_pixel_word[23:16];
        s1_nxt.blue  = direct ? in_pixel_word[23:16] : in_pixel_word[7:0];
      end
      bmp_px_pkg::MODE_RGBA32: begin
        if (lr.ok && lg.ok && lb.ok && la.ok) begin
          s1_nxt.red       = in_pixel_word[8*lr.lane +: 8];
          s1_nxt.green     = in_pixel_word[8*lg.lane +: 8];
          s1_nxt.blue      = in_pixel_word[8*lb.lane +: 8];
          s1_nxt.alpha     = in_pixel_word[8*la.lane +: 8];
          s1_nxt.has_alpha = 1'b1;
        end else begin
          s1_nxt.error = 1'b1;
        end
      end
      default: s1_nxt.error = 1'b1;
    endcase
  end

  logic [2:0][15:0]     fs_r;
  logic [2:0][15:0]     ms_r;
  bmp_px_pkg::pix_res_t s1_r;
  logic                 m16_s1_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      fs_r     <= fs_nxt;
      ms_r     <= ms_nxt;
      s1_r     <= s1_nxt;
      m16_s1_r <= (pixel_mode_r == bmp_px_pkg::MODE_MASK16);
    end
  end

  // stage 2: measure the run of ones and trim each field to it
  logic [2:0][4:0]  wd_nxt;
  logic [2:0][15:0] f_nxt;
  logic [16:0]      keep;

  always_comb begin
    keep = 17'd0;
    for (int c = 0; c < 3; c++) begin
      wd_nxt[c] = to16(ms_r[c]);
      keep      = (17'd1 << wd_nxt[c]) - 17'd1;
      f_nxt[c]  = fs_r[c] & keep[15:0];
    end
  end

  logic [2:0][4:0]      wd_r;
  logic [2:0][15:0]     f_r;
  bmp_px_pkg::pix_res_t s2_r;
  logic                 m16_s2_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      wd_r     <= wd_nxt;
      f_r      <= f_nxt;
      s2_r     <= s1_r;
      m16_s2_r <= m16_s1_r;
    end
  end

  // stage 3: widen to 8 bits and pick the result
  bmp_px_pkg::pix_res_t s3_nxt;

  always_comb begin
    s3_nxt = s2_r;
    if (m16_s2_r) begin
      s3_nxt.red   = widen(f_r[0], wd_r[0]);
      s3_nxt.green = widen(f_r[1], wd_r[1]);
      s3_nxt.blue  = widen(f_r[2], wd_r[2]);
    end
  end

  bmp_px_pkg::pix_res_t s3_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_r <= s3_nxt;
    end
  end

  assign out_red       = s3_r.red;
  assign out_green     = s3_r.green;
  assign out_blue      = s3_r.blue;
  assign out_alpha     = s3_r.alpha;
  assign out_has_alpha = s3_r.has_alpha;
  assign out_error     = s3_r.error;

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = bmp_px_pkg::REG_PIXEL_MODE;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pixel_word = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic        out_has_alpha;
  logic        out_error;

  bmp_pixel_to_rgba8 uut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_pixel_word(in_pixel_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red(out_red),
    .out_green(out_green),
    .out_blue(out_blue),
    .out_alpha(out_alpha),
    .out_has_alpha(out_has_alpha),
    .out_error(out_error)
  );

  // format registers as the block should hold them
  logic [1:0]  fmt_mode = bmp_px_pkg::MODE_MASK16;
  logic [31:0] red_sel = bmp_px_pkg::RST_RED_MASK;
  logic [31:0] green_sel = bmp_px_pkg::RST_GREEN_MASK;
  logic [31:0] blue_sel = bmp_px_pkg::RST_BLUE_MASK;
  logic [31:0] alpha_sel = bmp_px_pkg::RST_ALPHA_MASK;

  logic [31:0]          pixel_q[$];
  bmp_px_pkg::pix_res_t rgba_expect[$];
  bmp_px_pkg::pix_res_t next_rgba;
  logic [31:0] dropped_word;
  logic        in_took = 1'b0;
  int          mismatches = 0;
  int          results_seen = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          hold_left = 0;
  int          next_hold_at = 80;
  int          seg_left = 0;
  int          stall_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] widen_channel(input logic [15:0] word,
                                               input logic [31:0] mask);
    logic [15:0] m;
    logic [31:0] f;
    logic [31:0] acc;
    int sh;
    int wd;
    int pos;
    m = mask[15:0];
    if (m == 16'd0) return 8'd0;
    sh = 0;
    while (!m[sh]) sh++;
    wd = 0;
    while (sh + wd < 16 && m[sh + wd]) wd++;
    f = {16'd0, word & m} >> sh;
    f = f & ((32'd1 << wd) - 32'd1);
    if (wd >= 8) begin
      f = f >> (wd - 8);
      return f[7:0];
    end
    acc = '0;
    pos = 8;
    while (pos > 0) begin
      pos -= wd;
      if (pos >= 0) acc = acc | (f << pos);
      else acc = acc | (f >> (-pos));
    end
    return acc[7:0];
  endfunction

  function automatic int byte_lane(input logic [31:0] mask);
    case (mask)
      bmp_px_pkg::LANE0_MASK: return 0;
      bmp_px_pkg::LANE1_MASK: return 1;
      bmp_px_pkg::LANE2_MASK: return 2;
      bmp_px_pkg::LANE3_MASK: return 3;
      default: return -1;
    endcase
  endfunction

  function automatic bmp_px_pkg::pix_res_t predict_rgba(input logic [31:0] word);
    bmp_px_pkg::pix_res_t res;
    int lr;
    int lg;
    int lb;
    int la;
    res = '0;
    lr = byte_lane(red_sel);
    lg = byte_lane(green_sel);
    lb = byte_lane(blue_sel);
    la = byte_lane(alpha_sel);
    case (fmt_mode)
      bmp_px_pkg::MODE_MASK16: begin
        res.red = widen_channel(word[15:0], red_sel);
        res.green = widen_channel(word[15:0], green_sel);
        res.blue = widen_channel(word[15:0], blue_sel);
        if (alpha_sel != '0) begin
          res.has_alpha = 1'b1;
          res.alpha = |(word[15:0] & alpha_sel[15:0]) ? bmp_px_pkg::FULL_BYTE : 8'd0;
        end
      end
      bmp_px_pkg::MODE_RGB24: begin
        res.green = word[15:8];
        if (red_sel == bmp_px_pkg::LANE0_MASK && green_sel == bmp_px_pkg::LANE1_MASK &&
            blue_sel == bmp_px_pkg::LANE2_MASK) begin
          res.red = word[7:0];
          res.blue = word[23:16];
        end else begin
          res.red = word[23:16];
          res.blue = word[7:0];
        end
      end
      bmp_px_pkg::MODE_RGBA32: begin
        if (lr < 0 || lg < 0 || lb < 0 || la < 0) begin
          res.error = 1'b1;
        end else begin
          res.red = word[8 * lr +: 8];
          res.green = word[8 * lg +: 8];
          res.blue = word[8 * lb +: 8];
          res.alpha = word[8 * la +: 8];
          res.has_alpha = 1'b1;
        end
      end
      default: res.error = 1'b1;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatches < 100)
      $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    if (got !== want) report_mismatch(what, {24'd0, got}, {24'd0, want});
  endtask

  always @(posedge clk) begin
    in_took <= rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          bmp_px_pkg::REG_PIXEL_MODE: fmt_mode = cfg_data[1:0];
          bmp_px_pkg::REG_RED_MASK: red_sel = cfg_data;
          bmp_px_pkg::REG_GREEN_MASK: green_sel = cfg_data;
          bmp_px_pkg::REG_BLUE_MASK: blue_sel = cfg_data;
          bmp_px_pkg::REG_ALPHA_MASK: alpha_sel = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        rgba_expect.push_back(predict_rgba(in_pixel_word));
        dropped_word = pixel_q.pop_front();
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (rgba_expect.size() == 0) begin
          report_mismatch("result word with none pending",
                          {out_red, out_green, out_blue, out_alpha}, 32'd0);
        end else begin
          next_rgba = rgba_expect.pop_front();
          compare_field("red", out_red, next_rgba.red);
          compare_field("green", out_green, next_rgba.green);
          compare_field("blue", out_blue, next_rgba.blue);
          compare_field("alpha", out_alpha, next_rgba.alpha);
          compare_field("has_alpha", {7'd0, out_has_alpha}, {7'd0, next_rgba.has_alpha});
          compare_field("error", {7'd0, out_error}, {7'd0, next_rgba.error});
        end
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // hold until taken
    end else begin
      if (in_took) burst_left--;
      if (burst_left <= 0) begin
        burst_left = $urandom_range(24, 1);
        gap_left = ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
      end
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        in_valid <= 1'b1;
        in_pixel_word <= pixel_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (results_seen >= next_hold_at) begin
      hold_left = 39;
      next_hold_at += 165;
      out_stall <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(60, 10);
        stall_pct = 30 * $urandom_range(3);
      end
      seg_left--;
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_format(input logic [1:0] mode, input logic [31:0] r,
                            input logic [31:0] g, input logic [31:0] b,
                            input logic [31:0] a);
    write_reg(bmp_px_pkg::REG_PIXEL_MODE, {30'd0, mode});
    write_reg(bmp_px_pkg::REG_RED_MASK, r);
    write_reg(bmp_px_pkg::REG_GREEN_MASK, g);
    write_reg(bmp_px_pkg::REG_BLUE_MASK, b);
    write_reg(bmp_px_pkg::REG_ALPHA_MASK, a);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic drain;
    while (pixel_q.size() != 0 || rgba_expect.size() != 0 || in_valid) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_pair(input logic [31:0] w0, input logic [31:0] w1);
    pixel_q.push_back(w0);
    pixel_q.push_back(w1);
    drain();
  endtask

  function automatic logic [31:0] rand_field_mask();
    int sh;
    int wd;
    logic [31:0] m;
    sh = $urandom_range(15);
    wd = $urandom_range(16 - sh, 1);
    m = ((32'd1 << wd) - 32'd1) << sh;
    case ($urandom_range(7))
      0: m = '0;
      1: m = $urandom;
      2: m = m | ($urandom & 32'hffff_0000);
      default: ;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] random_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: w = '0;
      1: w = '1;
      2, 3: w[31:16] = '0;
      4: w[31:24] = '0;
      default: ;
    endcase
    return w;
  endfunction

  task automatic random_format;
    int pick;
    logic [1:0] mode;
    logic [31:0] m[4];
    pick = $urandom_range(9);
    if (pick < 4) mode = bmp_px_pkg::MODE_MASK16;
    else if (pick < 6) mode = bmp_px_pkg::MODE_RGB24;
    else if (pick < 9) mode = bmp_px_pkg::MODE_RGBA32;
    else mode = MODE_UNUSED;
    foreach (m[i]) begin
      case (mode)
        bmp_px_pkg::MODE_MASK16: m[i] = rand_field_mask();
        bmp_px_pkg::MODE_RGBA32: begin
          if ($urandom_range(7) == 0) m[i] = $urandom;
          else m[i] = bmp_px_pkg::LANE0_MASK << (8 * $urandom_range(3));
        end
        default: m[i] = $urandom;
      endcase
    end
    if (mode == bmp_px_pkg::MODE_RGB24 && $urandom_range(1) == 1) begin
      m[0] = bmp_px_pkg::LANE0_MASK;
      m[1] = bmp_px_pkg::LANE1_MASK;
      m[2] = bmp_px_pkg::LANE2_MASK;
    end
    if (mode == bmp_px_pkg::MODE_MASK16 && $urandom_range(2) == 0) m[3] = '0;
    set_format(mode, m[0], m[1], m[2], m[3]);
  endtask

  initial begin
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    send_pair(32'h0000_ffff, 32'h0000_0000);
    set_format(bmp_px_pkg::MODE_MASK16, 32'h0000_7c00, 32'h0000_03e0, 32'h0000_001f,
               32'h0000_8000);
    send_pair(32'h0000_8000, 32'h0000_7fff);
    set_format(bmp_px_pkg::MODE_MASK16, 32'h0000_0f00, 32'h0000_00f0, 32'h0000_000f,
               32'h0000_f000);
    send_pair(32'h0000_1234, 32'hffff_0000);
    set_format(bmp_px_pkg::MODE_MASK16, '1, '1, '1, '1);
    send_pair(32'hffff_ffff, 32'h0000_5a5a);
    set_format(bmp_px_pkg::MODE_MASK16, '0, '0, '0, '0);
    send_pair(32'hffff_ffff, 32'h1234_5678);
    set_format(bmp_px_pkg::MODE_MASK16, 32'h0000_0f0f, 32'h0000_fff0, 32'hffff_0000,
               32'h0001_0000);
    send_pair(32'hffff_ffff, 32'h0000_a5a5);
    set_format(bmp_px_pkg::MODE_MASK16, 32'h0000_0001, 32'h0000_8000, 32'h0000_0006,
               32'h0000_0003);
    send_pair(32'h0000_8001, 32'h0000_0006);
    set_format(bmp_px_pkg::MODE_RGB24, bmp_px_pkg::LANE0_MASK, bmp_px_pkg::LANE1_MASK,
               bmp_px_pkg::LANE2_MASK, '0);
    send_pair(32'hff12_3456, 32'h00ab_cdef);
    set_format(bmp_px_pkg::MODE_RGB24, bmp_px_pkg::RST_RED_MASK, bmp_px_pkg::RST_GREEN_MASK,
               bmp_px_pkg::RST_BLUE_MASK, '0);
    send_pair(32'hff12_3456, 32'h00ab_cdef);
    set_format(bmp_px_pkg::MODE_RGBA32, bmp_px_pkg::LANE2_MASK, bmp_px_pkg::LANE1_MASK,
               bmp_px_pkg::LANE0_MASK, bmp_px_pkg::LANE3_MASK);
    send_pair(32'h1122_3344, 32'hffff_ffff);
    set_format(bmp_px_pkg::MODE_RGBA32, bmp_px_pkg::LANE0_MASK, bmp_px_pkg::LANE0_MASK,
               bmp_px_pkg::LANE3_MASK, bmp_px_pkg::LANE3_MASK);
    send_pair(32'h8000_0001, 32'h1234_5678);
    set_format(bmp_px_pkg::MODE_RGBA32, 32'h0000_00fe, bmp_px_pkg::LANE1_MASK,
               bmp_px_pkg::LANE2_MASK, bmp_px_pkg::LANE3_MASK);
    send_pair(32'hffff_ffff, 32'h1234_5678);
    set_format(MODE_UNUSED, bmp_px_pkg::LANE0_MASK, bmp_px_pkg::LANE1_MASK,
               bmp_px_pkg::LANE2_MASK, bmp_px_pkg::LANE3_MASK);
    send_pair(32'hffff_ffff, 32'h1234_5678);

    repeat (12) begin
      random_format();
      repeat (36) pixel_q.push_back(random_word());
      drain();
    end

    repeat (10) @(posedge clk);
    if (rgba_expect.size() != 0)
      report_mismatch("results never produced", 32'(rgba_expect.size()), 32'd0);
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
